// ----- rtl/twqt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twqt_pkg
// Shared types and constants of the windowed throughput trigger: register
// layout, reset values, item kinds and the command codes of the job queue.
// ----------------------------------------------------------------------------
package twqt_pkg;

	// Field widths fixed by the interface.
	localparam int KIND_W     = 2;
	localparam int LEN_W      = 32;
	localparam int RATE_W     = 16;
	localparam int HOLD_W     = 16;
	localparam int GAP_W      = 24;
	localparam int WIN_W      = 24;
	// A window sum is at most window_us plus one gap, so one extra bit holds it.
	localparam int WTIME_W    = WIN_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int CMD_W      = 2;

	// Input item kinds.
	localparam logic [KIND_W-1:0] KIND_XFER  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd3;

	// Commands handed from the front end to the back end.
	localparam logic [CMD_W-1:0] CMD_MEAS  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd2;

	// Result codes.
	localparam logic EV_MEASURED = 1'b0;
	localparam logic EV_EXPIRED  = 1'b1;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd3;

	// Register reset values.
	localparam logic [GAP_W-1:0]  RST_GAP_LIMIT = 24'd500000;
	localparam logic [WIN_W-1:0]  RST_WINDOW    = 24'd1000000;
	localparam logic [RATE_W-1:0] RST_THRESHOLD = 16'd40;
	localparam logic [HOLD_W-1:0] RST_HOLD      = 16'd200;

	// bytes/us to MB/s: x * 1000000 / 2^20 == x * 15625 / 2^14.
	localparam int               MBPS_SHIFT = 14;
	localparam int               MBPS_MUL_W = 14;
	localparam logic [MBPS_MUL_W-1:0] MBPS_MUL = 14'd15625;
	// Quotients at or above 2^30 saturate the rate in any case.
	localparam int               QUO_USE_W  = RATE_W + MBPS_SHIFT;
	localparam int               PROD_W     = QUO_USE_W + MBPS_MUL_W;

	typedef struct packed {
		logic [GAP_W-1:0]  gap_limit_us;
		logic [WIN_W-1:0]  window_us;
		logic [RATE_W-1:0] rate_threshold_mbps;
		logic [HOLD_W-1:0] hold_ticks;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/twqt_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twqt_fifo
// Small job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module twqt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output logic [WIDTH-1:0]      pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) push |-> (!full || pop);
	endproperty
	assert property (p_no_overflow) else $error("job queue written while full");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> not_empty;
	endproperty
	assert property (p_no_underflow) else $error("job queue read while empty");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH);
	endproperty
	assert property (p_count_bound) else $error("job queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/twqt_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twqt_front
// Accepts items, takes the gap to the previous transfer, keeps the window
// sums and queues measure, tick and close jobs for the back end.
// ----------------------------------------------------------------------------
module twqt_front
	import twqt_pkg::*;
#(
	parameter int TIME_BITS     = 48,
	parameter int BYTE_SUM_BITS = 48
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cfg_t                     cfg,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [KIND_W-1:0]        kind,
	input  wire logic [TIME_BITS-1:0]     timestamp_us,
	input  wire logic [LEN_W-1:0]         request_length,
	output logic                          push,
	output logic [CMD_W-1:0]              push_cmd,
	output logic [WTIME_W-1:0]            push_time,
	output logic [BYTE_SUM_BITS-1:0]      push_bytes,
	input  wire logic                     queue_full
);

	// Stage 1: gap against the last stamp.
	logic                  v_s1;
	logic [KIND_W-1:0]     kind_s1;
	logic [LEN_W-1:0]      len_s1;
	logic [GAP_W-1:0]      gap_s1;
	logic                  over_s1;
	logic [TIME_BITS-1:0]  last_stamp_q;
	logic [TIME_BITS-1:0]  gap;

	// Stage 2: window sums.
	logic [WIN_W-1:0]          wtime_q;
	logic [BYTE_SUM_BITS-1:0]  wbytes_q;
	logic [WTIME_W-1:0]        sum_time;
	logic [BYTE_SUM_BITS:0]    sum_bytes;
	logic [BYTE_SUM_BITS-1:0]  sat_bytes;
	logic                      win_full;
	logic                      need_push;
	logic                      advance;
	logic                      accept;

	assign gap    = timestamp_us - last_stamp_q;
	assign accept = in_valid && in_ready;

	assign sum_time  = WTIME_W'(wtime_q) + WTIME_W'(gap_s1);
	assign sum_bytes = {1'b0, wbytes_q} + (BYTE_SUM_BITS + 1)'(len_s1);
	assign sat_bytes = sum_bytes[BYTE_SUM_BITS] ? '1 : sum_bytes[BYTE_SUM_BITS-1:0];
	assign win_full  = (sum_time > WTIME_W'(cfg.window_us));

	always_comb begin
		need_push = 1'b0;
		push_cmd  = CMD_MEAS;
		unique case (kind_s1)
			KIND_XFER: begin
				need_push = !over_s1 && win_full;
				push_cmd  = CMD_MEAS;
			end
			KIND_TICK: begin
				need_push = 1'b1;
				push_cmd  = CMD_TICK;
			end
			KIND_CLOSE: begin
				need_push = 1'b1;
				push_cmd  = CMD_CLOSE;
			end
			default: begin
				need_push = 1'b0;
				push_cmd  = CMD_MEAS;
			end
		endcase
	end

	assign push       = v_s1 && need_push && !queue_full;
	assign advance    = v_s1 && (!need_push || !queue_full);
	assign in_ready   = !v_s1 || advance;
	assign push_time  = sum_time;
	assign push_bytes = sat_bytes;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			len_s1  <= request_length;
			gap_s1  <= gap[GAP_W-1:0];
			over_s1 <= (gap > TIME_BITS'(cfg.gap_limit_us));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1         <= 1'b0;
			last_stamp_q <= '0;
			wtime_q      <= '0;
			wbytes_q     <= '0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (accept && kind == KIND_XFER) begin
				last_stamp_q <= timestamp_us;
			end else if (accept && kind == KIND_OPEN) begin
				last_stamp_q <= '0;
			end
			if (advance) begin
				if (kind_s1 == KIND_OPEN || (kind_s1 == KIND_XFER && (over_s1 || win_full))) begin
					wtime_q  <= '0;
					wbytes_q <= '0;
				end else if (kind_s1 == KIND_XFER) begin
					wtime_q  <= sum_time[WIN_W-1:0];
					wbytes_q <= sat_bytes;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/twqt_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// twqt_back
// Executes queued jobs in order: divides the window bytes by its time one
// quotient bit per cycle, scales to MB/s, runs the hold countdown and drives
// the result register.
// ----------------------------------------------------------------------------
module twqt_back
	import twqt_pkg::*;
#(
	parameter int BYTE_SUM_BITS = 48
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire cfg_t                     cfg,
	input  wire logic                     job_valid,
	output logic                          job_pop,
	input  wire logic [CMD_W-1:0]         job_cmd,
	input  wire logic [WTIME_W-1:0]       job_time,
	input  wire logic [BYTE_SUM_BITS-1:0] job_bytes,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          event_res,
	output logic [RATE_W-1:0]             throughput_mbps,
	output logic                          enter_performance
);

	localparam int CNT_W = $clog2(BYTE_SUM_BITS);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]               state_q;
	logic [HOLD_W-1:0]        hold_q;
	logic [BYTE_SUM_BITS-1:0] dvd_q;
	logic [WTIME_W-1:0]       rem_q;
	logic [WTIME_W-1:0]       dsr_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [RATE_W-1:0]        rate_q;
	logic                     out_valid_q;
	logic                     event_q;
	logic [RATE_W-1:0]        mbps_q;
	logic                     enter_q;

	logic                     out_free;
	logic                     res_load;
	logic [WTIME_W:0]         trial;
	logic                     ge;
	logic [WTIME_W:0]         diff;
	logic [PROD_W-1:0]        prod;
	logic [QUO_USE_W-1:0]     scaled;
	logic                     quo_big;
	logic [RATE_W-1:0]        rate_nxt;
	logic                     hit;

	assign out_free = !out_valid_q || out_ready;
	assign job_pop  = (state_q == ST_IDLE) && job_valid && out_free;

	// A result is loaded by a tick that ends the hold or by a finished measurement.
	assign res_load = (job_pop && job_cmd == CMD_TICK && hold_q == HOLD_W'(1)) ||
	                  (state_q == ST_FIN && out_free);

	// One restoring step: the remainder always stays below the divisor.
	assign trial = {rem_q, dvd_q[BYTE_SUM_BITS-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = (trial >= {1'b0, dsr_q});

	assign quo_big  = |dvd_q[BYTE_SUM_BITS-1:QUO_USE_W];
	assign prod     = dvd_q[QUO_USE_W-1:0] * MBPS_MUL;
	assign scaled   = prod[PROD_W-1:MBPS_SHIFT];
	assign rate_nxt = (quo_big || (|scaled[QUO_USE_W-1:RATE_W])) ? '1 : scaled[RATE_W-1:0];
	assign hit      = (rate_q >= cfg.rate_threshold_mbps);

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job_pop) begin
					dvd_q <= job_bytes;
					dsr_q <= job_time;
					rem_q <= '0;
					cnt_q <= CNT_W'(BYTE_SUM_BITS - 1);
				end
			end
			ST_DIV: begin
				rem_q <= ge ? diff[WTIME_W-1:0] : trial[WTIME_W-1:0];
				dvd_q <= {dvd_q[BYTE_SUM_BITS-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_MUL: begin
				rate_q <= rate_nxt;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
			event_q     <= EV_MEASURED;
			mbps_q      <= '0;
			enter_q     <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_pop) begin
						case (job_cmd)
							CMD_MEAS: begin
								state_q <= ST_DIV;
							end
							CMD_TICK: begin
								if (hold_q != '0) begin
									hold_q <= hold_q - 1'b1;
									if (hold_q == HOLD_W'(1)) begin
										event_q     <= EV_EXPIRED;
										mbps_q      <= '0;
										enter_q     <= 1'b0;
									end
								end
							end
							default: begin
								hold_q <= '0;
							end
						endcase
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						event_q     <= EV_MEASURED;
						mbps_q      <= rate_q;
						enter_q     <= hit && (hold_q == '0);
						if (hit) begin
							hold_q <= cfg.hold_ticks;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign event_res         = event_q;
	assign throughput_mbps   = mbps_q;
	assign enter_performance = enter_q;

	property p_div_nonzero;
		@(posedge clk) disable iff (!arst_n)
			(job_pop && job_cmd == CMD_MEAS) |-> (job_time != '0);
	endproperty
	assert property (p_div_nonzero) else $error("measure job with zero window time");

	property p_close_clears;
		@(posedge clk) disable iff (!arst_n)
			(job_pop && job_cmd == CMD_CLOSE) |=> (hold_q == '0);
	endproperty
	assert property (p_close_clears) else $error("close did not cancel the hold");

	property p_enter_needs_hit;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_FIN && out_free && !hit) |=> !enter_q;
	endproperty
	assert property (p_enter_needs_hit) else $error("performance request below threshold");

	property p_expired_clean;
		@(posedge clk) disable iff (!arst_n)
			(out_valid_q && event_q == EV_EXPIRED) |-> (mbps_q == '0 && !enter_q);
	endproperty
	assert property (p_expired_clean) else $error("expiry beat carries a rate");

endmodule
`default_nettype wire

// ----- rtl/throughput_window_qos_trigger.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// throughput_window_qos_trigger
// Windowed transfer throughput meter with a performance-mode hold countdown.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake              Beat contents
// input     in         in_valid / in_ready    kind, timestamp_us, request_length
// output    out        out_valid / out_ready  event_res, throughput_mbps,
//                                             enter_performance
// config    in         cfg_wr_en              cfg_index, cfg_data
//
// Transfers that do not close a window, session opens, ticks and closes are
// taken one per cycle, ticks and closes only while the job queue has room; the
// front end registers the gap, then the window sums, in a two-stage pipeline.
// A transfer that closes a window takes the back end through the restoring
// divider (one quotient bit per cycle), one scaling multiply and one result
// step. A four-entry job queue lets the front end keep accepting beats while
// the back end divides, and stalls the input only when that queue is full.
// The output register frees the back end as soon as a result is loaded; a
// stalled output holds the back end before it loads a result or takes its
// next job. Reset is asynchronous and immediate: there is no clearing pass.
//
// The gap is taken modulo 2^TIME_BITS. A gap above gap_limit_us restarts the
// window; otherwise gap and bytes accumulate (bytes saturate). Once the window
// time exceeds window_us, the rate floor(floor(bytes/us) * 1000000 / 2^20),
// saturated to 16 bits, is reported and the window cleared. A rate at or above
// rate_threshold_mbps reloads the hold, and requests performance mode when no
// hold was running. Ticks count the hold down and report its expiry.
// ----------------------------------------------------------------------------
module throughput_window_qos_trigger
	import twqt_pkg::*;
#(
	parameter int TIME_BITS     = 48,
	parameter int BYTE_SUM_BITS = 48
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Configuration writes.
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// Input beats.
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [KIND_W-1:0]     kind,
	input  wire logic [TIME_BITS-1:0]  timestamp_us,
	input  wire logic [LEN_W-1:0]      request_length,
	// Result beats.
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       event_res,
	output logic [RATE_W-1:0]          throughput_mbps,
	output logic                       enter_performance
);

	// One queue entry carries the command, the window time and the byte sum.
	localparam int JOB_W       = CMD_W + WTIME_W + BYTE_SUM_BITS;
	localparam int QUEUE_DEPTH = 4;

	cfg_t cfg_q;

	logic                     push;
	logic [CMD_W-1:0]         push_cmd;
	logic [WTIME_W-1:0]       push_time;
	logic [BYTE_SUM_BITS-1:0] push_bytes;
	logic                     queue_full;
	logic                     job_valid;
	logic                     job_pop;
	logic [JOB_W-1:0]         job_data;

	// The register file: the user must write it only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit_us        <= RST_GAP_LIMIT;
			cfg_q.window_us           <= RST_WINDOW;
			cfg_q.rate_threshold_mbps <= RST_THRESHOLD;
			cfg_q.hold_ticks          <= RST_HOLD;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GAP_LIMIT: cfg_q.gap_limit_us        <= cfg_data[GAP_W-1:0];
				CFG_WINDOW:    cfg_q.window_us           <= cfg_data[WIN_W-1:0];
				CFG_THRESHOLD: cfg_q.rate_threshold_mbps <= cfg_data[RATE_W-1:0];
				CFG_HOLD:      cfg_q.hold_ticks          <= cfg_data[HOLD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: gap, window sums and job generation.
	twqt_front #(
		.TIME_BITS     (TIME_BITS),
		.BYTE_SUM_BITS (BYTE_SUM_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.timestamp_us   (timestamp_us),
		.request_length (request_length),
		.push           (push),
		.push_cmd       (push_cmd),
		.push_time      (push_time),
		.push_bytes     (push_bytes),
		.queue_full     (queue_full)
	);

	// Job queue: keeps tick, close and measure jobs in arrival order so the
	// hold countdown sees them exactly as the items came in.
	twqt_fifo #(
		.WIDTH (JOB_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_cmd, push_time, push_bytes}),
		.full      (queue_full),
		.pop       (job_pop),
		.not_empty (job_valid),
		.pop_data  (job_data)
	);

	// Back end: division, scaling, hold countdown and result register.
	twqt_back #(
		.BYTE_SUM_BITS (BYTE_SUM_BITS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.job_valid         (job_valid),
		.job_pop           (job_pop),
		.job_cmd           (job_data[JOB_W-1 -: CMD_W]),
		.job_time          (job_data[BYTE_SUM_BITS +: WTIME_W]),
		.job_bytes         (job_data[BYTE_SUM_BITS-1:0]),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.event_res         (event_res),
		.throughput_mbps   (throughput_mbps),
		.enter_performance (enter_performance)
	);

endmodule
`default_nettype wire
